// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands. The module that uses them must
// have a clock named clk and an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define LSN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lsn: assertion failed");

// Check that a condition implies another in the same cycle
`define LSN_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsn: implication failed");

// Check that a condition implies another in the next cycle
`define LSN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsn: next-cycle implication failed");

`endif

// File: rtl/lsn_pkg.sv
// ----------------------------------------------------------------------------
// lsn_pkg
// Types and constants shared by the link supervision block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsn_pkg;

    // Event codes
    typedef enum logic [2:0] {
        OP_PERIODIC  = 3'd0,
        OP_BOOTUP    = 3'd1,
        OP_HEARTBEAT = 3'd2,
        OP_SDO_RESP  = 3'd3,
        OP_SYNC_DONE = 3'd4
    } op_t;

    // Commands to transmit
    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_BOOTUP      = 3'd1,
        CMD_PDO_MAP     = 3'd2,
        CMD_SYNC        = 3'd3,
        CMD_SET_OP      = 3'd4,
        CMD_HEARTBEAT   = 3'd5,
        CMD_SET_STOPPED = 3'd6
    } cmd_t;

    // Link state
    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_PREOP = 2'd1,
        MODE_OP    = 2'd2,
        MODE_STOP  = 2'd3
    } mode_t;

    // Pre-operational sub-step
    typedef enum logic [2:0] {
        STEP_IDLE      = 3'd0,
        STEP_WAIT_ACK  = 3'd1,
        STEP_SEND_SYNC = 3'd2,
        STEP_WAIT_SYNC = 3'd3,
        STEP_WAIT_HB   = 3'd4
    } step_t;

    // Configuration register indexes
    localparam logic [2:0] REG_BOOTUP_PERIOD = 3'd0;
    localparam logic [2:0] REG_INIT_TIMEOUT  = 3'd1;
    localparam logic [2:0] REG_PREOP_HB_TO   = 3'd2;
    localparam logic [2:0] REG_SDO_ACK_TO    = 3'd3;
    localparam logic [2:0] REG_SDO_MAX_TRIES = 3'd4;
    localparam logic [2:0] REG_SYNC_TIMEOUT  = 3'd5;
    localparam logic [2:0] REG_OP_HB_TO      = 3'd6;
    localparam logic [2:0] REG_OWN_HB_PERIOD = 3'd7;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Register reset values
    localparam logic [15:0] RST_BOOTUP_PERIOD = 16'd1000;
    localparam logic [15:0] RST_INIT_TIMEOUT  = 16'd5000;
    localparam logic [15:0] RST_PREOP_HB_TO   = 16'd5000;
    localparam logic [15:0] RST_SDO_ACK_TO    = 16'd1000;
    localparam logic [2:0]  RST_SDO_MAX_TRIES = 3'd3;
    localparam logic [15:0] RST_SYNC_TIMEOUT  = 16'd3000;
    localparam logic [15:0] RST_OP_HB_TO      = 16'd1000;
    localparam logic [15:0] RST_OWN_HB_PERIOD = 16'd200;

    // Fixed waits in the stopped state
    localparam logic [15:0] STOP_RESET_MS = 16'd2000;
    localparam logic [15:0] STOP_RETRY_MS = 16'd3000;

    typedef struct packed {
        logic [15:0] bootup_period_ms;
        logic [15:0] init_timeout_ms;
        logic [15:0] preop_heartbeat_timeout_ms;
        logic [15:0] sdo_ack_timeout_ms;
        logic [2:0]  sdo_max_tries;
        logic [15:0] sync_timeout_ms;
        logic [15:0] op_heartbeat_timeout_ms;
        logic [15:0] own_heartbeat_period_ms;
    } cfg_t;

    // One accepted event
    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ms;
        logic        data_ready;
        logic        cm_is_operational;
        logic        sdo_reply_to_request;
        logic        sdo_is_pdo_mapping;
        logic        sdo_ok;
    } ev_t;

    // Everything one event produces: up to two commands and the new state
    typedef struct packed {
        cmd_t  cmd0;
        cmd_t  cmd1;
        logic  two;
        mode_t link_state;
        logic  connected;
        logic  clear;
    } step_res_t;

endpackage

`default_nettype wire

// File: rtl/lsn_if.sv
// ----------------------------------------------------------------------------
// lsn_if
// Valid/ready channels for supervisor events and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsn_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] now_ms;
    logic        data_ready;
    logic        cm_is_operational;
    logic        sdo_reply_to_request;
    logic        sdo_is_pdo_mapping;
    logic        sdo_ok;

    modport source (
        output valid, operation, now_ms, data_ready, cm_is_operational,
               sdo_reply_to_request, sdo_is_pdo_mapping, sdo_ok,
        input  ready
    );
    modport sink (
        input  valid, operation, now_ms, data_ready, cm_is_operational,
               sdo_reply_to_request, sdo_is_pdo_mapping, sdo_ok,
        output ready
    );
endinterface

interface lsn_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] send_command;
    logic [1:0] link_state;
    logic       link_connected;
    logic       clear_rx_data;
    logic       last;

    modport source (
        output valid, send_command, link_state, link_connected, clear_rx_data, last,
        input  ready
    );
    modport sink (
        input  valid, send_command, link_state, link_connected, clear_rx_data, last,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/lsn_step.sv
// ----------------------------------------------------------------------------
// lsn_step
// Link state registers and the single-pass update for one event.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lsn_step
    import lsn_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire ev_t       ev,
    input  wire cfg_t      cfg,
    output step_res_t      res
);

    typedef logic [TIME_BITS-1:0] tm_t;

    mode_t mode_reg, mode_next;
    step_t step_reg, step_next;
    logic  partner_op_reg, partner_op_next;
    logic  connected_reg, connected_next;
    logic  synced_reg, synced_next;
    logic  states_synced_reg, states_synced_next;
    logic  reset_sent_reg, reset_sent_next;
    logic [2:0] retry_reg, retry_next;
    tm_t   hb_time_reg, hb_time_next;
    tm_t   sdo_time_reg, sdo_time_next;
    tm_t   init_entry_reg, init_entry_next;
    tm_t   bootup_time_reg, bootup_time_next;
    tm_t   sync_time_reg, sync_time_next;
    tm_t   own_hb_time_reg, own_hb_time_next;
    tm_t   stop_entry_reg, stop_entry_next;

    tm_t   now;
    tm_t   lim_bootup, lim_init, lim_preop_hb, lim_ack, lim_sync, lim_op_hb, lim_own_hb;
    tm_t   lim_stop_reset, lim_stop_retry;

    // Wrapping difference of two time stamps
    function automatic tm_t elapsed(input tm_t a, input tm_t b);
        return a - b;
    endfunction

    // Bring time and limits to the time width
    assign now            = TIME_BITS'(ev.now_ms);
    assign lim_bootup     = TIME_BITS'(cfg.bootup_period_ms);
    assign lim_init       = TIME_BITS'(cfg.init_timeout_ms);
    assign lim_preop_hb   = TIME_BITS'(cfg.preop_heartbeat_timeout_ms);
    assign lim_ack        = TIME_BITS'(cfg.sdo_ack_timeout_ms);
    assign lim_sync       = TIME_BITS'(cfg.sync_timeout_ms);
    assign lim_op_hb      = TIME_BITS'(cfg.op_heartbeat_timeout_ms);
    assign lim_own_hb     = TIME_BITS'(cfg.own_heartbeat_period_ms);
    assign lim_stop_reset = TIME_BITS'(STOP_RESET_MS);
    assign lim_stop_retry = TIME_BITS'(STOP_RETRY_MS);

    // Hold link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_INIT;
            step_reg          <= STEP_IDLE;
            partner_op_reg    <= 1'b0;
            connected_reg     <= 1'b0;
            synced_reg        <= 1'b0;
            states_synced_reg <= 1'b0;
            reset_sent_reg    <= 1'b0;
            retry_reg         <= '0;
            hb_time_reg       <= '0;
            sdo_time_reg      <= '0;
            init_entry_reg    <= '0;
            bootup_time_reg   <= '0;
            sync_time_reg     <= '0;
            own_hb_time_reg   <= '0;
            stop_entry_reg    <= '0;
        end
        else if (fire)
        begin
            mode_reg          <= mode_next;
            step_reg          <= step_next;
            partner_op_reg    <= partner_op_next;
            connected_reg     <= connected_next;
            synced_reg        <= synced_next;
            states_synced_reg <= states_synced_next;
            reset_sent_reg    <= reset_sent_next;
            retry_reg         <= retry_next;
            hb_time_reg       <= hb_time_next;
            sdo_time_reg      <= sdo_time_next;
            init_entry_reg    <= init_entry_next;
            bootup_time_reg   <= bootup_time_next;
            sync_time_reg     <= sync_time_next;
            own_hb_time_reg   <= own_hb_time_next;
            stop_entry_reg    <= stop_entry_next;
        end
    end

    // Compute next state and commands for the event
    always_comb
    begin
        logic [1:0] ncmd;
        cmd_t       c0;
        cmd_t       c1;
        cmd_t       want;
        logic       do_emit;
        logic       go_stop;

        mode_next          = mode_reg;
        step_next          = step_reg;
        partner_op_next    = partner_op_reg;
        connected_next     = connected_reg;
        synced_next        = synced_reg;
        states_synced_next = states_synced_reg;
        reset_sent_next    = reset_sent_reg;
        retry_next         = retry_reg;
        hb_time_next       = hb_time_reg;
        sdo_time_next      = sdo_time_reg;
        init_entry_next    = init_entry_reg;
        bootup_time_next   = bootup_time_reg;
        sync_time_next     = sync_time_reg;
        own_hb_time_next   = own_hb_time_reg;
        stop_entry_next    = stop_entry_reg;
        ncmd    = 2'd0;
        c0      = CMD_NONE;
        c1      = CMD_NONE;
        want    = CMD_NONE;
        do_emit = 1'b0;
        go_stop = 1'b0;

        unique case (ev.operation)
            OP_PERIODIC:
            begin
                unique case (mode_reg)
                    MODE_INIT:
                    begin
                        if (init_entry_next == '0)
                            init_entry_next = now;
                        if (elapsed(now, bootup_time_reg) > lim_bootup)
                        begin
                            c0               = CMD_BOOTUP;
                            ncmd             = 2'd1;
                            bootup_time_next = now;
                        end
                        if (elapsed(now, init_entry_next) > lim_init)
                        begin
                            go_stop         = 1'b1;
                            init_entry_next = '0;
                        end
                    end
                    MODE_PREOP:
                    begin
                        if (elapsed(now, hb_time_reg) > lim_preop_hb)
                            go_stop = 1'b1;
                        else
                        begin
                            unique case (step_reg)
                                STEP_WAIT_ACK:
                                begin
                                    if (elapsed(now, sdo_time_reg) > lim_ack)
                                    begin
                                        if (retry_reg < cfg.sdo_max_tries)
                                        begin
                                            step_next  = STEP_IDLE;
                                            retry_next = retry_reg + 3'd1;
                                        end
                                        else
                                            go_stop = 1'b1;
                                    end
                                end
                                STEP_SEND_SYNC, STEP_WAIT_SYNC:
                                begin
                                    if (step_reg == STEP_SEND_SYNC)
                                    begin
                                        c0             = CMD_SYNC;
                                        ncmd           = 2'd1;
                                        sync_time_next = now;
                                        step_next      = STEP_WAIT_SYNC;
                                    end
                                    if (elapsed(now, sync_time_next) > lim_sync)
                                        go_stop = 1'b1;
                                    else if (states_synced_reg)
                                    begin
                                        want          = CMD_SET_OP;
                                        do_emit       = 1'b1;
                                        sdo_time_next = now;
                                        hb_time_next  = now;
                                        step_next     = STEP_WAIT_HB;
                                    end
                                end
                                STEP_WAIT_HB:
                                begin
                                    if (elapsed(now, hb_time_reg) > lim_sync)
                                        go_stop = 1'b1;
                                end
                                default:
                                begin
                                    // idle and meaningless codes request the mapping
                                    c0            = CMD_PDO_MAP;
                                    ncmd          = 2'd1;
                                    sdo_time_next = now;
                                    retry_next    = 3'd1;
                                    step_next     = STEP_WAIT_ACK;
                                end
                            endcase
                        end
                    end
                    MODE_OP:
                    begin
                        if ((elapsed(now, hb_time_reg) > lim_op_hb) || !partner_op_reg)
                            go_stop = 1'b1;
                        else
                        begin
                            if (elapsed(now, own_hb_time_reg) > lim_own_hb)
                            begin
                                c0               = CMD_HEARTBEAT;
                                ncmd             = 2'd1;
                                own_hb_time_next = now;
                            end
                            if (ev.data_ready)
                                synced_next = 1'b1;
                        end
                    end
                    MODE_STOP:
                    begin
                        if (stop_entry_next == '0)
                        begin
                            stop_entry_next = now;
                            reset_sent_next = 1'b0;
                        end
                        if (!reset_sent_next &&
                            (elapsed(now, stop_entry_next) > lim_stop_reset))
                        begin
                            c0              = CMD_SET_STOPPED;
                            ncmd            = 2'd1;
                            reset_sent_next = 1'b1;
                        end
                        if (elapsed(now, stop_entry_next) > lim_stop_retry)
                        begin
                            mode_next       = MODE_INIT;
                            stop_entry_next = '0;
                        end
                    end
                endcase
            end
            OP_BOOTUP:
            begin
                if (mode_reg == MODE_INIT)
                begin
                    hb_time_next    = now;
                    mode_next       = MODE_PREOP;
                    step_next       = STEP_IDLE;
                    init_entry_next = '0;
                end
            end
            OP_HEARTBEAT:
            begin
                hb_time_next    = now;
                partner_op_next = ev.cm_is_operational;
                if (mode_reg == MODE_PREOP && step_reg == STEP_WAIT_HB)
                begin
                    connected_next = 1'b1;
                    mode_next      = MODE_OP;
                end
                else if (mode_reg == MODE_INIT)
                    go_stop = 1'b1;
            end
            OP_SDO_RESP:
            begin
                if (ev.sdo_reply_to_request && mode_reg == MODE_PREOP &&
                    step_reg == STEP_WAIT_ACK && ev.sdo_is_pdo_mapping)
                begin
                    if (ev.sdo_ok)
                    begin
                        sdo_time_next      = now;
                        hb_time_next       = now;
                        step_next          = STEP_SEND_SYNC;
                        states_synced_next = 1'b0;
                    end
                    else
                        go_stop = 1'b1;
                end
            end
            OP_SYNC_DONE:
            begin
                states_synced_next = 1'b1;
            end
            default:
            begin
                // unknown event codes change nothing
            end
        endcase

        // Append the set-operational command after any earlier one
        if (do_emit)
        begin
            if (ncmd == 2'd0)
            begin
                c0   = want;
                ncmd = 2'd1;
            end
            else
            begin
                c1   = want;
                ncmd = 2'd2;
            end
        end

        // Drop the link
        if (go_stop)
        begin
            connected_next     = 1'b0;
            synced_next        = 1'b0;
            states_synced_next = 1'b0;
            mode_next          = MODE_STOP;
        end

        res.cmd0       = c0;
        res.cmd1       = c1;
        res.two        = (ncmd == 2'd2);
        res.link_state = mode_next;
        res.connected  = connected_next & synced_next;
        res.clear      = go_stop;
    end

    `LSN_ASSERT_IMPL(a_clear_means_stop, fire && res.clear, res.link_state == MODE_STOP)
    `LSN_ASSERT_IMPL(a_two_is_sync_setop, fire && res.two,
                     res.cmd0 == CMD_SYNC && res.cmd1 == CMD_SET_OP)
    `LSN_ASSERT_IMPL(a_op_is_connected, mode_reg == MODE_OP, connected_reg)

endmodule

`default_nettype wire

// File: rtl/lsn_out.sv
// ----------------------------------------------------------------------------
// lsn_out
// Two-event result queue; splits an event with two commands into two
// result transfers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lsn_out
    import lsn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire step_res_t din,
    output logic           space,
    lsn_result_if.source   res
);

    step_res_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       sub_reg, sub_next;
    step_res_t  head;
    logic       is_last;
    logic       xfer;
    logic       pop;

    assign head    = q_reg[rd_ptr_reg];
    assign is_last = !head.two || sub_reg;
    assign xfer    = res.valid && res.ready;
    assign pop     = xfer && is_last;
    assign space   = (cnt_reg != 2'd2);

    // Present the head entry
    assign res.valid          = (cnt_reg != 2'd0);
    assign res.send_command   = sub_reg ? head.cmd1 : head.cmd0;
    assign res.link_state     = head.link_state;
    assign res.link_connected = head.connected;
    assign res.clear_rx_data  = head.clear && is_last;
    assign res.last           = is_last;

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= din;
    end

    // Advance pointers, count and sub-result index
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
        sub_next    = sub_reg;
        if (xfer)
            sub_next = !is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            sub_reg    <= sub_next;
        end
    end

    `LSN_ASSERT(a_cnt_range, cnt_reg != 2'd3)
    `LSN_ASSERT_IMPL(a_sub_needs_two, sub_reg && cnt_reg != 2'd0, head.two)
    `LSN_ASSERT_NEXT(a_first_then_second, xfer && !is_last, sub_reg && res.valid)

endmodule

`default_nettype wire

// File: rtl/link_supervision_nmt_fsm.sv
// ----------------------------------------------------------------------------
// link_supervision_nmt_fsm
// Node link supervisor: boot-up, heartbeat and mapping handshake, with
// wrapping millisecond timeouts and a stop/retry cycle.
//
//   Channel  Dir  Carries
//   ev       in   operation, now_ms, event qualifiers
//   res      out  send_command, link_state, link_connected, clear_rx_data, last
//   cfg_*    in   register write (index 0..7, 16-bit data)
//
// An event is processed while it sits in the input register and its results
// are written to the result queue when it fires, so the first result is
// offered from the queue register, after the input register and any stall.
// One event per cycle is taken while the queue has space; an event with two
// commands needs two result transfers, so the result side sets the rate then.
// A two-event result queue decouples the sides; the input stalls only when
// the queue is full. Reset clears all link state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module link_supervision_nmt_fsm
    import lsn_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    lsn_event_if.sink                     ev,
    lsn_result_if.source                  res,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic ev_valid_reg, ev_valid_next;
    ev_t  ev_reg;
    logic space;
    logic fire;
    logic take;
    step_res_t step_res;

    assign fire     = ev_valid_reg && space;
    assign ev.ready = !ev_valid_reg || fire;
    assign take     = ev.valid && ev.ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bootup_period_ms           <= RST_BOOTUP_PERIOD;
            cfg_reg.init_timeout_ms            <= RST_INIT_TIMEOUT;
            cfg_reg.preop_heartbeat_timeout_ms <= RST_PREOP_HB_TO;
            cfg_reg.sdo_ack_timeout_ms         <= RST_SDO_ACK_TO;
            cfg_reg.sdo_max_tries              <= RST_SDO_MAX_TRIES;
            cfg_reg.sync_timeout_ms            <= RST_SYNC_TIMEOUT;
            cfg_reg.op_heartbeat_timeout_ms    <= RST_OP_HB_TO;
            cfg_reg.own_heartbeat_period_ms    <= RST_OWN_HB_PERIOD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOOTUP_PERIOD: cfg_reg.bootup_period_ms           <= cfg_wdata;
                REG_INIT_TIMEOUT:  cfg_reg.init_timeout_ms            <= cfg_wdata;
                REG_PREOP_HB_TO:   cfg_reg.preop_heartbeat_timeout_ms <= cfg_wdata;
                REG_SDO_ACK_TO:    cfg_reg.sdo_ack_timeout_ms         <= cfg_wdata;
                REG_SDO_MAX_TRIES: cfg_reg.sdo_max_tries              <= cfg_wdata[2:0];
                REG_SYNC_TIMEOUT:  cfg_reg.sync_timeout_ms            <= cfg_wdata;
                REG_OP_HB_TO:      cfg_reg.op_heartbeat_timeout_ms    <= cfg_wdata;
                REG_OWN_HB_PERIOD: cfg_reg.own_heartbeat_period_ms    <= cfg_wdata;
            endcase
        end
    end

    // Hold the accepted event until it is processed
    always_comb
    begin
        ev_valid_next = ev_valid_reg;
        if (take)
            ev_valid_next = 1'b1;
        else if (fire)
            ev_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ev_valid_reg <= 1'b0;
        else
            ev_valid_reg <= ev_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ev_reg.operation            <= ev.operation;
            ev_reg.now_ms               <= ev.now_ms;
            ev_reg.data_ready           <= ev.data_ready;
            ev_reg.cm_is_operational    <= ev.cm_is_operational;
            ev_reg.sdo_reply_to_request <= ev.sdo_reply_to_request;
            ev_reg.sdo_is_pdo_mapping   <= ev.sdo_is_pdo_mapping;
            ev_reg.sdo_ok               <= ev.sdo_ok;
        end
    end

    lsn_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ev    (ev_reg),
        .cfg   (cfg_reg),
        .res   (step_res)
    );

    lsn_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .din   (step_res),
        .space (space),
        .res   (res)
    );

endmodule

`default_nettype wire
